[rtl/irko_pkg.sv]
// shared types, constants and helpers for the inverter relay keep-on controller
package irko_pkg;

  localparam int TimerBits = 20;
  localparam int SatBits = TimerBits + 21;
  localparam int OutTimerBits = 20;
  localparam int ButtonExtraS = 60 * 60 * 2;
  localparam int SettingLoad = 5;
  localparam int MinOnReset = 15 * 60;
  localparam int LowLoadReset = 100;

  typedef logic [TimerBits-1:0] timer_t;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_ON       = 3'd1,
    MODE_SETTING  = 3'd2,
    MODE_KEEP_ON  = 3'd3,
    MODE_AUTO_OFF = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_BUTTON    = 2'd1,
    FUNC_REMOTE_ON = 2'd2,
    FUNC_RELEASE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_AUTO_OFF_EN = 2'd0,
    CFG_LOW_LOAD    = 2'd1,
    CFG_MIN_ON      = 2'd2
  } cfg_idx_e;

  // clamp a wide value to the keep-on timer range
  function automatic timer_t sat_timer(input logic [SatBits-1:0] v);
    timer_t r;
    if (|v[SatBits-1:TimerBits]) begin
      r = '1;
    end else begin
      r = v[TimerBits-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/inverter_relay_keep_on_controller_top.sv]
// relay keep-on controller: input stage, event update and result/state registers
// an accepted item is held in the input stage register, then its result in the state registers
// throughput: one item per cycle; the state update is one pass of logic
// after the input register, and the result stalls only on out_ready_i
// reset: mode off, relay open, timers and request count zero,
// config registers back to auto off on, 100 W threshold, 900 s minimum on
module inverter_relay_keep_on_controller_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [1:0]                           cfg_index_i,
  input  logic [15:0]                          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           func_i,
  input  logic [15:0]                          load_power_w_i,
  input  logic [19:0]                          keep_on_seconds_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 relay_closed_o,
  output logic [2:0]                           mode_now_o,
  output logic [irko_pkg::OutTimerBits-1:0]    remaining_keep_on_s_o,
  output logic [7:0]                           open_requests_o
);
  import irko_pkg::*;

  // configuration registers
  logic        auto_off_en_q;
  logic [15:0] low_load_q;
  logic [15:0] min_on_q;

  // input stage
  logic        s1_valid_q;
  func_e       s1_func_q;
  logic [15:0] s1_load_q;
  logic [19:0] s1_keep_q;

  // state, which is also the result register
  logic        out_valid_q, out_valid_d;
  mode_e       mode_q, mode_d;
  timer_t      keep_on_q, keep_on_d;
  logic [2:0]  setting_q, setting_d;
  logic [7:0]  req_q, req_d;
  logic        relay_q, relay_d;

  logic        advance;
  timer_t      keep_sat;
  logic [2:0]  setting_dec;
  timer_t      keep_on_dec;
  logic [7:0]  req_dec;
  logic [SatBits-1:0] timer_wide;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_off_en_q <= 1'b1;
      low_load_q    <= 16'(LowLoadReset);
      min_on_q      <= 16'(MinOnReset);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_AUTO_OFF_EN: auto_off_en_q <= cfg_data_i[0];
        CFG_LOW_LOAD:    low_load_q    <= cfg_data_i;
        CFG_MIN_ON:      min_on_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_func_q <= func_e'(func_i);
      s1_load_q <= load_power_w_i;
      s1_keep_q <= keep_on_seconds_i;
    end
  end

  assign keep_sat    = sat_timer(SatBits'(s1_keep_q));
  assign setting_dec = (setting_q != 3'd0) ? setting_q - 3'd1 : setting_q;
  assign keep_on_dec = (keep_on_q != '0) ? keep_on_q - TimerBits'(1) : keep_on_q;
  assign req_dec     = req_q - 8'd1;

  always_comb begin
    mode_d    = mode_q;
    keep_on_d = keep_on_q;
    setting_d = setting_q;
    req_d     = req_q;
    relay_d   = relay_q;
    case (s1_func_q)
      FUNC_TICK: begin
        case (mode_q)
          MODE_ON: begin
            if (auto_off_en_q) mode_d = MODE_KEEP_ON;
          end
          MODE_SETTING: begin
            setting_d = setting_dec;
            if (setting_dec == 3'd0) mode_d = MODE_KEEP_ON;
          end
          MODE_KEEP_ON: begin
            keep_on_d = keep_on_dec;
            if (keep_on_dec == '0) mode_d = MODE_AUTO_OFF;
          end
          MODE_AUTO_OFF: begin
            if (!auto_off_en_q) begin
              mode_d = MODE_ON;
            end else if (s1_load_q < low_load_q) begin
              relay_d = 1'b0;
              mode_d  = MODE_OFF;
            end
          end
          default: ;
        endcase
      end
      FUNC_BUTTON: begin
        case (mode_q)
          MODE_ON, MODE_KEEP_ON, MODE_AUTO_OFF: begin
            relay_d = 1'b0;
            mode_d  = MODE_OFF;
          end
          MODE_SETTING: begin
            keep_on_d = sat_timer(SatBits'(keep_on_q) + SatBits'(ButtonExtraS));
          end
          default: begin
            // off, and codes that are never produced
            keep_on_d = sat_timer(SatBits'(min_on_q));
            mode_d    = MODE_SETTING;
            setting_d = 3'(SettingLoad);
            relay_d   = 1'b1;
          end
        endcase
      end
      FUNC_REMOTE_ON: begin
        if (req_q != 8'hff) req_d = req_q + 8'd1;
        if (keep_on_q < keep_sat) keep_on_d = keep_sat;
        mode_d  = MODE_KEEP_ON;
        relay_d = 1'b1;
      end
      FUNC_RELEASE: begin
        // a release with no open requests is dropped
        if (req_q != 8'd0) begin
          req_d = req_dec;
          if (req_dec == 8'd0) mode_d = MODE_AUTO_OFF;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= MODE_OFF;
      keep_on_q   <= '0;
      setting_q   <= 3'd0;
      req_q       <= 8'd0;
      relay_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        mode_q    <= mode_d;
        keep_on_q <= keep_on_d;
        setting_q <= setting_d;
        req_q     <= req_d;
        relay_q   <= relay_d;
      end
    end
  end

  assign timer_wide            = SatBits'(keep_on_q);
  assign out_valid_o           = out_valid_q;
  assign relay_closed_o        = relay_q;
  assign mode_now_o            = mode_q;
  assign remaining_keep_on_s_o = timer_wide[OutTimerBits-1:0];
  assign open_requests_o       = req_q;

  // setting mode is only entered with the relay closed and never opens it
  a_setting_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_SETTING) |-> relay_q)
    else $error("relay open in setting mode");

  a_off_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_OFF) |-> !relay_q)
    else $error("relay closed in off mode");

  a_setting_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    setting_q <= 3'(SettingLoad))
    else $error("setting timer above its load value");

  // a stalled result must not be overwritten by the next item
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(keep_on_q) && $stable(mode_q)
      && $stable(req_q) && $stable(relay_q)))
    else $error("state changed while result stalled");

endmodule
